// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("property check failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== rtl/mssc_pkg.sv =====
`default_nettype none
package mssc_pkg;

	// Size of each byte store; must be a power of two.
	localparam int MEM_BYTES = 65536;
	localparam int ADDR_BITS = $clog2(MEM_BYTES);
	localparam int NBANK     = 4;
	localparam int ROWS      = MEM_BYTES / NBANK;
	localparam int ROW_BITS  = ADDR_BITS - 2;

	localparam logic [2:0] ACT_STEP = 3'd0;
	localparam logic [2:0] ACT_LDI  = 3'd1;
	localparam logic [2:0] ACT_LDD  = 3'd2;
	localparam logic [2:0] ACT_RDR  = 3'd3;
	localparam logic [2:0] ACT_RDW  = 3'd4;

	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_ADDIU = 6'h09;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_SW    = 6'h2B;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_J     = 6'h02;

	localparam logic [2:0] ALU_ADD = 3'd1;
	localparam logic [2:0] ALU_SUB = 3'd3;
	localparam logic [2:0] ALU_AND = 3'd4;
	localparam logic [2:0] ALU_OR  = 3'd5;
	localparam logic [2:0] ALU_NOR = 3'd7;

	localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

	typedef struct packed {
		logic cap;
		logic clr;
		logic iss;
		logic dec;
		logic exe;
		logic mem;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic step_go;
		logic halt_word;
	} stat_t;

	// Row of bank k that holds one of the four bytes of the word at byte address a.
	function automatic logic [ROW_BITS-1:0] bank_row(logic [ADDR_BITS-1:0] a, logic [1:0] k);
		return a[ADDR_BITS-1:2] + ROW_BITS'(k < a[1:0]);
	endfunction

	// Big-endian word from the four bank outputs, first byte in bank rot.
	function automatic logic [31:0] be_word(logic [NBANK-1:0][7:0] bk, logic [1:0] rot);
		logic [31:0] w;
		w = '0;
		for (int i = 0; i < NBANK; i++) begin
			w = {w[23:0], bk[rot + 2'(i)]};
		end
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/mssc_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module mssc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  mssc_pkg::stat_t   stat,
	output mssc_pkg::cmd_t    cmd
);
	import mssc_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CLEAR = 7'b0000010,
		S_ISSUE = 7'b0000100,
		S_DEC   = 7'b0001000,
		S_EXE   = 7'b0010000,
		S_MEM   = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.cap = in_valid;
				if (in_valid) state_d = S_ISSUE;
			end
			S_ISSUE: begin
				cmd.iss = 1'b1;
				state_d = stat.step_go ? S_DEC : S_FIN;
			end
			S_DEC: begin
				cmd.dec = 1'b1;
				state_d = stat.halt_word ? S_FIN : S_EXE;
			end
			S_EXE: begin
				cmd.exe = 1'b1;
				state_d = S_MEM;
			end
			S_MEM: begin
				cmd.mem = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				// The result register must be free before the word is committed.
				cmd.fin = !out_valid_q || !out_stall;
				if (cmd.fin) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	`ASSERT_IMPL(a_fin_valid, clk, arst_n, cmd.fin |=> out_valid_q)
	`ASSERT_IMPL(a_acc_issue, clk, arst_n, (in_valid && !in_stall) |=> (state_q == S_ISSUE))
	`ASSERT_NEVER(a_fin_blocked, clk, arst_n, cmd.fin && out_valid_q && out_stall)
endmodule
`default_nettype wire

// ===== rtl/mssc_dp.sv =====
`default_nettype none
`include "assert_macros.svh"
module mssc_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  mssc_pkg::cmd_t  cmd,
	output mssc_pkg::stat_t stat,
	input  logic [2:0]      action,
	input  logic [15:0]     mem_address,
	input  logic [7:0]      load_byte,
	input  logic [4:0]      register_index,
	output logic [31:0]     next_pc,
	output logic            halted,
	output logic            reg_write_done,
	output logic [4:0]      write_target,
	output logic [31:0]     write_value,
	output logic [31:0]     read_value
);
	import mssc_pkg::*;

	logic [7:0] imem [NBANK][ROWS];
	logic [7:0] dmem [NBANK][ROWS];
	logic [31:0] rf_mem [32];

	logic [2:0]           act_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [7:0]           byte_q;
	logic [4:0]           ridx_q;

	logic [31:0] pc_q, pc4_q, npc_q, alu_q, instr_q, b_q;
	logic [2:0]  alu_code_q;
	logic        halt_q, exec_q, wb_en_q, is_lw_q, is_sw_q;
	logic [4:0]  wb_tgt_q;
	logic [31:0] rf_vld_q;
	logic [31:0] rfa_rd_q, rfb_rd_q;
	logic [ROW_BITS-1:0] clr_q;

	logic [NBANK-1:0][7:0] imem_rd_q, dmem_rd_q;
	logic [1:0] irot_q, drot_q;

	logic [31:0] next_pc_q, write_value_q, read_value_q;
	logic        halted_q, reg_write_done_q;
	logic [4:0]  write_target_q;

	logic [31:0] fword, dword;
	logic [ROW_BITS-1:0] im_row [NBANK];
	logic [ROW_BITS-1:0] dm_row [NBANK];
	logic [NBANK-1:0] im_we, dm_we;
	logic [7:0] im_wd [NBANK];
	logic [7:0] dm_wd [NBANK];
	logic [ADDR_BITS-1:0] i_a, d_a;
	logic im_re, dm_re;
	logic [3:0][7:0] sw_bytes;

	logic [4:0]  rfa_idx;
	logic        rfa_re, rf_we;
	logic [31:0] wb_val;

	logic [5:0]  op;
	logic        is_r, is_i, is_lw, is_sw, is_beq, is_j;
	logic [31:0] simm, opb;
	logic [2:0]  code_n;
	logic [31:0] alu_n;

	assign fword = be_word(imem_rd_q, irot_q);
	assign dword = be_word(dmem_rd_q, drot_q);

	assign stat.clr_last  = (clr_q == ROW_BITS'(ROWS - 1));
	assign stat.step_go   = (act_q == ACT_STEP) && !halt_q;
	assign stat.halt_word = (fword == HALT_WORD);

	// Byte stores: four banks by low address bits, so a word at any byte
	// address is one row in each bank.
	assign i_a      = (cmd.iss && act_q == ACT_LDI) ? addr_q : pc_q[ADDR_BITS-1:0];
	assign d_a      = cmd.mem ? alu_q[ADDR_BITS-1:0] : addr_q;
	assign im_re    = cmd.iss && stat.step_go;
	assign dm_re    = (cmd.iss && act_q == ACT_RDW) || (cmd.mem && is_lw_q);
	assign sw_bytes = b_q;

	always_comb begin
		for (int k = 0; k < NBANK; k++) begin
			im_row[k] = cmd.clr ? clr_q : bank_row(i_a, 2'(k));
			dm_row[k] = cmd.clr ? clr_q : bank_row(d_a, 2'(k));
			im_we[k]  = cmd.clr || (cmd.iss && act_q == ACT_LDI && addr_q[1:0] == 2'(k));
			im_wd[k]  = cmd.clr ? 8'h00 : byte_q;
			dm_we[k]  = cmd.clr || (cmd.iss && act_q == ACT_LDD && addr_q[1:0] == 2'(k))
				|| (cmd.mem && is_sw_q);
			if (cmd.clr) dm_wd[k] = 8'h00;
			else if (cmd.mem) dm_wd[k] = sw_bytes[2'd3 - (2'(k) - d_a[1:0])];
			else dm_wd[k] = byte_q;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NBANK; k++) begin
			if (im_we[k]) imem[k][im_row[k]] <= im_wd[k];
			if (im_re) imem_rd_q[k] <= imem[k][im_row[k]];
			if (dm_we[k]) dmem[k][dm_row[k]] <= dm_wd[k];
			if (dm_re) dmem_rd_q[k] <= dmem[k][dm_row[k]];
		end
		if (im_re) irot_q <= i_a[1:0];
		if (dm_re) drot_q <= d_a[1:0];
	end

	// Register file: entries never written read as zero through the valid bits.
	assign rfa_idx = cmd.dec ? fword[25:21] : ridx_q;
	assign rfa_re  = cmd.dec || (cmd.iss && act_q == ACT_RDR);
	assign rf_we   = cmd.fin && exec_q && wb_en_q && (wb_tgt_q != 5'd0);
	assign wb_val  = is_lw_q ? dword : alu_q;

	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[wb_tgt_q] <= wb_val;
		if (rfa_re) rfa_rd_q <= rf_vld_q[rfa_idx] ? rf_mem[rfa_idx] : 32'd0;
		if (cmd.dec) rfb_rd_q <= rf_vld_q[fword[20:16]] ? rf_mem[fword[20:16]] : 32'd0;
	end

	// Execute stage decode and ALU.
	assign op     = instr_q[31:26];
	assign is_r   = (op == OP_RTYPE);
	assign is_i   = (op == OP_ADDIU);
	assign is_lw  = (op == OP_LW);
	assign is_sw  = (op == OP_SW);
	assign is_beq = (op == OP_BEQ);
	assign is_j   = (op == OP_J);
	assign simm   = {{16{instr_q[15]}}, instr_q[15:0]};
	assign opb    = (is_i || is_lw || is_sw) ? simm : rfb_rd_q;

	always_comb begin
		if (is_i || is_lw || is_sw) code_n = ALU_ADD;
		else if (is_r) code_n = instr_q[2:0];
		else if (is_beq) code_n = ALU_SUB;
		else code_n = alu_code_q;
		case (code_n)
			ALU_ADD: alu_n = rfa_rd_q + opb;
			ALU_SUB: alu_n = rfa_rd_q - opb;
			ALU_AND: alu_n = rfa_rd_q & opb;
			ALU_OR:  alu_n = rfa_rd_q | opb;
			ALU_NOR: alu_n = ~(rfa_rd_q | opb);
			default: alu_n = alu_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			act_q  <= action;
			addr_q <= mem_address[ADDR_BITS-1:0];
			byte_q <= load_byte;
			ridx_q <= register_index;
		end
		if (cmd.dec) begin
			instr_q <= fword;
			pc4_q   <= pc_q + 32'd4;
		end
		if (cmd.exe) begin
			b_q      <= rfb_rd_q;
			wb_en_q  <= is_r || is_i || is_lw;
			wb_tgt_q <= is_r ? instr_q[15:11] : instr_q[20:16];
			is_lw_q  <= is_lw;
			is_sw_q  <= is_sw;
			if (is_beq && rfa_rd_q == rfb_rd_q) npc_q <= pc4_q + {simm[29:0], 2'b00};
			else if (is_j) npc_q <= {pc4_q[31:28], instr_q[25:0], 2'b00};
			else npc_q <= pc4_q;
		end
		if (cmd.fin) begin
			next_pc_q        <= exec_q ? npc_q : pc_q;
			halted_q         <= halt_q;
			reg_write_done_q <= rf_we;
			write_target_q   <= (exec_q && wb_en_q) ? wb_tgt_q : 5'd0;
			write_value_q    <= (exec_q && wb_en_q) ? wb_val : 32'd0;
			if (act_q == ACT_RDR) read_value_q <= rfa_rd_q;
			else if (act_q == ACT_RDW) read_value_q <= dword;
			else read_value_q <= 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= '0;
			halt_q     <= 1'b0;
			alu_code_q <= '0;
			alu_q      <= '0;
			exec_q     <= 1'b0;
			rf_vld_q   <= '0;
			clr_q      <= '0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + ROW_BITS'(1);
			if (cmd.cap) exec_q <= 1'b0;
			if (cmd.dec && stat.halt_word) halt_q <= 1'b1;
			if (cmd.exe) begin
				alu_code_q <= code_n;
				alu_q      <= alu_n;
				exec_q     <= 1'b1;
			end
			if (cmd.fin && exec_q) pc_q <= npc_q;
			if (rf_we) rf_vld_q[wb_tgt_q] <= 1'b1;
		end
	end

	assign next_pc        = next_pc_q;
	assign halted         = halted_q;
	assign reg_write_done = reg_write_done_q;
	assign write_target   = write_target_q;
	assign write_value    = write_value_q;
	assign read_value     = read_value_q;

	`ASSERT_NEVER(a_r0_valid, clk, arst_n, rf_vld_q[0])
	`ASSERT_IMPL(a_halt_sticky, clk, arst_n, halt_q |=> halt_q)
	`ASSERT_NEVER(a_exec_halted, clk, arst_n, cmd.exe && halt_q)
endmodule
`default_nettype wire

// ===== rtl/mips_subset_single_cycle_core.sv =====
`default_nettype none
// MIPS subset core (addu, subu, and, or, nor, addiu, lw, sw, beq, j) with its own
// byte-wide big-endian instruction and data stores and a 32-entry register file.
// After reset the core zeroes both stores one row per cycle, with in_stall high.
// A step word then goes from acceptance to result through accept, fetch, register
// read, execute, data access and write-back, set by the synchronous reads of the
// instruction store, the register file and the data store in turn; a step that
// fetches the halt word skips execute and data access, and load and read words, as
// well as steps while halted, go from accept and issue straight to the result. A
// result waits in an output register while the next word is accepted.
module mips_subset_single_cycle_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [15:0] mem_address,
	input  logic [7:0]  load_byte,
	input  logic [4:0]  register_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] next_pc,
	output logic        halted,
	output logic        reg_write_done,
	output logic [4:0]  write_target,
	output logic [31:0] write_value,
	output logic [31:0] read_value
);
	import mssc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mssc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	mssc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.action         (action),
		.mem_address    (mem_address),
		.load_byte      (load_byte),
		.register_index (register_index),
		.next_pc        (next_pc),
		.halted         (halted),
		.reg_write_done (reg_write_done),
		.write_target   (write_target),
		.write_value    (write_value),
		.read_value     (read_value)
	);
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mssc_pkg::*;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] addr;
		logic [7:0]  bval;
		logic [4:0]  ridx;
	} word_t;

	typedef struct packed {
		logic [31:0] pc;
		logic        halted;
		logic        wdone;
		logic [4:0]  wtarget;
		logic [31:0] wvalue;
		logic [31:0] rvalue;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [15:0] mem_address;
	logic [7:0]  load_byte;
	logic [4:0]  register_index;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] next_pc;
	logic        halted;
	logic        reg_write_done;
	logic [4:0]  write_target;
	logic [31:0] write_value;
	logic [31:0] read_value;

	mips_subset_single_cycle_core DUT (.*);

	// Core state as the checker sees it.
	logic [7:0]  imem [MEM_BYTES];
	logic [7:0]  dmem [MEM_BYTES];
	logic [31:0] gpr [32];
	logic [31:0] pc;
	logic [2:0]  alu_code;
	logic [31:0] alu_val;
	logic        halt_seen;

	word_t    pending_words [$];
	outcome_t expected_outcomes [$];
	int       mismatches = 0;
	int       sent = 0;
	int       gap = 0;
	int       stall_left = 0;
	logic     quiet = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] fetch_be(ref logic [7:0] mem [MEM_BYTES], input logic [31:0] a);
		logic [31:0] w;
		w = '0;
		for (int i = 0; i < 4; i++)
			w = {w[23:0], mem[ADDR_BITS'(a + 32'(i))]};
		return w;
	endfunction

	function automatic outcome_t execute_word(word_t it);
		outcome_t r;
		logic [31:0] ins, a, b, simm, opnd, pc4;
		logic [5:0] op;
		logic [4:0] tgt;
		r = '0;
		case (it.action)
			ACT_LDI: imem[it.addr] = it.bval;
			ACT_LDD: dmem[it.addr] = it.bval;
			ACT_RDR: r.rvalue = gpr[it.ridx];
			ACT_RDW: r.rvalue = fetch_be(dmem, 32'(it.addr));
			ACT_STEP: if (!halt_seen) begin
				ins = fetch_be(imem, pc);
				if (ins == HALT_WORD) begin
					halt_seen = 1'b1;
				end else begin
					op = ins[31:26];
					a = gpr[ins[25:21]];
					b = gpr[ins[20:16]];
					simm = {{16{ins[15]}}, ins[15:0]};
					pc4 = pc + 32'd4;
					if (op == OP_LW || op == OP_SW || op == OP_ADDIU)
						alu_code = ALU_ADD;
					else if (op == OP_RTYPE)
						alu_code = ins[2:0];
					else if (op == OP_BEQ)
						alu_code = ALU_SUB;
					opnd = (op == OP_LW || op == OP_SW || op == OP_ADDIU) ? simm : b;
					case (alu_code)
						ALU_ADD: alu_val = a + opnd;
						ALU_SUB: alu_val = a - opnd;
						ALU_AND: alu_val = a & opnd;
						ALU_OR:  alu_val = a | opnd;
						ALU_NOR: alu_val = ~(a | opnd);
						default: ;
					endcase
					if (op == OP_SW)
						for (int i = 0; i < 4; i++)
							dmem[ADDR_BITS'(alu_val + 32'(i))] = b[31 - 8*i -: 8];
					if (op == OP_RTYPE || op == OP_ADDIU || op == OP_LW) begin
						tgt = (op == OP_RTYPE) ? ins[15:11] : ins[20:16];
						r.wtarget = tgt;
						r.wvalue = (op == OP_LW) ? fetch_be(dmem, alu_val) : alu_val;
						if (tgt != 5'd0) begin
							gpr[tgt] = r.wvalue;
							r.wdone = 1'b1;
						end
					end
					if (op == OP_BEQ && a == b)
						pc = pc4 + (simm << 2);
					else if (op == OP_J)
						pc = {pc4[31:28], ins[25:0], 2'b00};
					else
						pc = pc4;
				end
			end
			default: ;
		endcase
		r.pc = pc;
		r.halted = halt_seen;
		return r;
	endfunction

	task automatic queue_word(logic [2:0] act, logic [15:0] addr, logic [7:0] bv, logic [4:0] ri);
		word_t it;
		it = '{act, addr, bv, ri};
		expected_outcomes.push_back(execute_word(it));
		pending_words.push_back(it);
	endtask

	task automatic load_instr(logic [31:0] addr, logic [31:0] ins);
		for (int i = 0; i < 4; i++)
			queue_word(ACT_LDI, 16'(addr + 32'(i)), ins[31 - 8*i -: 8], 5'($urandom));
	endtask

	task automatic step_core();
		queue_word(ACT_STEP, 16'($urandom), 8'($urandom), 5'($urandom));
	endtask

	task automatic read_reg(logic [4:0] ri);
		queue_word(ACT_RDR, 16'($urandom), 8'($urandom), ri);
	endtask

	function automatic logic [31:0] rtype(int rs, int rt, int rd, logic [5:0] fn);
		return {OP_RTYPE, 5'(rs), 5'(rt), 5'(rd), 5'd0, fn};
	endfunction

	function automatic logic [31:0] itype(logic [5:0] op, int rs, int rt, logic [15:0] imm);
		return {op, 5'(rs), 5'(rt), imm};
	endfunction

	function automatic int pick_reg();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 7) : $urandom_range(0, 31);
	endfunction

	function automatic logic [31:0] random_instr(logic [31:0] at);
		logic [5:0] fn, op;
		int rs, rt, rd;
		rs = pick_reg();
		rt = pick_reg();
		rd = pick_reg();
		case ($urandom_range(0, 11))
			0, 1, 2: begin
				case ($urandom_range(0, 5))
					0: fn = 6'h21;
					1: fn = 6'h23;
					2: fn = 6'h24;
					3: fn = 6'h25;
					4: fn = 6'h27;
					default: fn = 6'($urandom);
				endcase
				return rtype(rs, rt, rd, fn);
			end
			3, 4: return itype(OP_ADDIU, rs, rt, 16'($urandom));
			5: return itype(OP_LW, rs, rt, 16'($urandom));
			6: return itype(OP_SW, rs, rt, 16'($urandom));
			7: return itype(OP_BEQ, rs, rt, ($urandom_range(0, 3) == 0) ?
				16'($urandom) : 16'($signed($urandom_range(0, 6)) - 3));
			8: return {OP_J, ($urandom_range(0, 2) == 0) ? 26'($urandom) :
				26'((at >> 2) + $urandom_range(0, 4))};
			9: return 32'($urandom);
			default: begin
				do op = 6'($urandom);
				while (op inside {OP_RTYPE, OP_ADDIU, OP_LW, OP_SW, OP_BEQ, OP_J});
				return {op, 26'($urandom)};
			end
		endcase
	endfunction

	initial begin
		logic [31:0] prog [$];
		logic [31:0] base;
		int n;
		for (int i = 0; i < MEM_BYTES; i++) begin
			imem[i] = '0;
			dmem[i] = '0;
		end
		for (int i = 0; i < 32; i++)
			gpr[i] = '0;
		pc = '0;
		alu_code = '0;
		alu_val = '0;
		halt_seen = 1'b0;

		// Directed: a data word that wraps past the top of the store, then one short
		// program with every operation, sign extension extremes and writes to r0.
		queue_word(ACT_LDD, 16'hFFFF, 8'hFF, 5'd0);
		queue_word(ACT_LDD, 16'h0000, 8'h80, 5'd31);
		queue_word(ACT_RDW, 16'hFFFE, 8'h00, 5'd0);
		prog = '{itype(OP_ADDIU, 0, 1, 16'h7FFF), itype(OP_ADDIU, 0, 2, 16'h8000),
			rtype(1, 2, 3, 6'h21), rtype(1, 2, 4, 6'h23), rtype(1, 2, 5, 6'h24),
			rtype(1, 2, 6, 6'h25), rtype(1, 2, 31, 6'h27), rtype(1, 2, 0, 6'h26),
			itype(OP_SW, 0, 31, 16'hFFFE), itype(OP_LW, 0, 7, 16'hFFFE),
			itype(OP_BEQ, 1, 1, 16'h0001), 32'hFC00_0000,
			{6'h3F, 26'h0}, {OP_J, 26'h0000040}};
		base = pc;
		foreach (prog[i])
			load_instr(base + 32'(4*i), prog[i]);
		foreach (prog[i])
			step_core();
		read_reg(5'd31);
		read_reg(5'd0);
		queue_word(ACT_RDW, 16'hFFFE, 8'h00, 5'd0);

		// Random programs loaded where the core will fetch next, with some noise.
		while (pending_words.size() < 2000) begin
			if ($urandom_range(0, 4) == 0) begin
				for (int k = 0; k < 4; k++)
					queue_word(3'($urandom), 16'($urandom), 8'($urandom), 5'($urandom));
			end else begin
				n = $urandom_range(2, 10);
				base = pc;
				for (int i = 0; i < n; i++)
					load_instr(base + 32'(4*i), random_instr(base + 32'(4*i)));
				for (int i = 0; i < 4; i++)
					queue_word(ACT_LDD, 16'($urandom), 8'($urandom), 5'($urandom));
				for (int i = 0; i < n + $urandom_range(0, 2); i++)
					step_core();
				read_reg(5'(pick_reg()));
				queue_word(ACT_RDW, 16'($urandom), 8'($urandom), 5'($urandom));
			end
		end

		// The halt word freezes the core for good, so it comes last.
		load_instr(pc, HALT_WORD);
		step_core();
		step_core();
		read_reg(5'd1);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= '0;
			mem_address <= '0;
			load_byte <= '0;
			register_index <= '0;
		end else if (!in_valid || !in_stall) begin
			if (gap > 0) begin
				gap <= gap - 1;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				word_t it;
				it = pending_words.pop_front();
				{action, mem_address, load_byte, register_index} <= it;
				in_valid <= 1'b1;
				sent <= sent + 1;
				if (sent % 250 == 0)
					quiet <= ~quiet;
				if (quiet || $urandom_range(0, 99) < 60)
					gap <= 0;
				else if ($urandom_range(0, 99) < 90)
					gap <= $urandom_range(1, 3);
				else
					gap <= $urandom_range(5, 30);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (!quiet && $urandom_range(0, 99) < 30)
				stall_left <= ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) :
					$urandom_range(5, 30);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			outcome_t got, want;
			got = '{next_pc, halted, reg_write_done, write_target, write_value, read_value};
			if (expected_outcomes.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result word: pc=%h halted=%b wdone=%b tgt=%0d wv=%h rv=%h",
						got.pc, got.halted, got.wdone, got.wtarget, got.wvalue, got.rvalue);
			end else begin
				want = expected_outcomes.pop_front();
				if (got !== want) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: expected pc=%h halted=%b wdone=%b tgt=%0d wv=%h rv=%h, got pc=%h halted=%b wdone=%b tgt=%0d wv=%h rv=%h",
							want.pc, want.halted, want.wdone, want.wtarget, want.wvalue,
							want.rvalue, got.pc, got.halted, got.wdone, got.wtarget,
							got.wvalue, got.rvalue);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		wait (pending_words.size() == 0 && !in_valid && expected_outcomes.size() == 0);
		repeat (30) @(posedge clk);
		if (mismatches == 0 && expected_outcomes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
